FILE: rtl/core/ttru_pkg.sv
// Package for the trickle timer with rank update.
// Types, codes and fixed constants shared by the interfaces and the top level.
// No dependencies.
package ttru_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned RND_W     = 32;
  localparam int unsigned CNT_W     = 5;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADV  = 2'd1;
  localparam logic [1:0] CMD_SOL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLINGS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REDUNDANCY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 3'd4;

  localparam logic [15:0]      RANK_UNKNOWN  = 16'hFFFF;
  localparam logic [15:0]      ETX_MAX       = 16'hFFFF;
  localparam logic [15:0]      FLOAT_ETX     = 16'd10000;
  localparam logic [15:0]      MIN_INT_RST   = 16'd5;
  localparam logic [4:0]       MAX_DOUBLINGS = 5'd16;
  localparam logic [RND_W-1:0] LFSR_TAPS     = 32'h8020_0003;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] parent_rank;
    logic [15:0] parent_etx;
    logic [7:0]  parent_version;
    logic [15:0] source_id;
  } in_word_t;

  typedef struct packed {
    logic        send_advert;
    logic        reply_advert;
    logic        stop_solicit;
    logic [15:0] node_rank;
    logic [15:0] node_etx;
    logic [7:0]  node_version;
    logic        is_grounded;
    logic [15:0] parent_id;
    logic        timer_running;
  } out_word_t;

endpackage

FILE: rtl/core/ttru_if.sv
// Valid/ready channel interfaces for the trickle timer block.
// Depends on ttru_pkg for the word types.
interface ttru_in_if import ttru_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ttru_out_if import ttru_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ttru_cfg_if import ttru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/trickle_timer_with_rank_update.sv
// Trickle timer with rank update: one word in, one result word out.
// Each accepted word passes the execute and response states; when a new fire
// point is drawn, the 32-step restoring remainder unit (one bit per cycle) runs between them.
// No new word is taken until the result of the last one is registered for output.
// Reset: async active low; config, identity, Trickle state and LFSR load
// their reset values at once, no clearing pass.
module trickle_timer_with_rank_update import ttru_pkg::*; #(
  parameter int unsigned TIMER_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttru_cfg_if.sink    cfg_i,
  ttru_in_if.sink     in_i,
  ttru_out_if.source  out_o
);

  localparam int unsigned TB = TIMER_BITS;
  localparam int unsigned WW = (TIMER_BITS > 32) ? TIMER_BITS : 32;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RND_W - 1);

  state_e state_q, state_d;

  // configuration
  logic [15:0]      min_int_q, min_int_d;
  logic [4:0]       dbl_cnt_q, dbl_cnt_d;
  logic [7:0]       red_q, red_d;
  logic             root_q, root_d;
  logic [RND_W-1:0] seed_q, seed_d;

  // trickle and identity state
  logic [TB-1:0]    int_q, int_d, fire_q, fire_d, elapsed_q, elapsed_d;
  logic [7:0]       cc_q, cc_d;
  logic             on_q, on_d, solicit_q, solicit_d, grounded_q, grounded_d;
  logic [15:0]      rank_q, rank_d, etx_q, etx_d, parent_q, parent_d;
  logic [7:0]       ver_q, ver_d;
  logic [RND_W-1:0] lfsr_q, lfsr_d;

  // item, flags, divider, output
  in_word_t         item_q, item_d;
  logic             send_q, send_d, reply_q, reply_d, stop_q, stop_d;
  logic [RND_W-1:0] div_q, div_d;
  logic [TB-1:0]    half_q, half_d, span_q, span_d, rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  out_word_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // combinational helpers
  logic [15:0]      min_eff;
  logic [4:0]       dbl_eff;
  logic [TB-1:0]    imin, imax, el_inc, dbl_sel, new_int, new_half;
  logic [WW-1:0]    top_ext;
  logic [TB:0]      dbl_wide, rem_shift, rem_sub;
  logic [RND_W-1:0] lfsr_nxt, seed_eff;
  logic             start, draw, better;
  logic [16:0]      p_rank_inc;

  always_comb begin
    min_eff  = (min_int_q == '0) ? 16'd1 : min_int_q;
    dbl_eff  = (dbl_cnt_q > MAX_DOUBLINGS) ? MAX_DOUBLINGS : dbl_cnt_q;
    imin     = TB'(min_eff);
    top_ext  = WW'(min_eff) << dbl_eff;
    imax     = (|(top_ext >> TB)) ? '1 : top_ext[TB-1:0];
    el_inc   = elapsed_q + TB'(1);
    dbl_wide = {int_q, 1'b0};
    dbl_sel  = (dbl_wide > {1'b0, imax}) ? imax : dbl_wide[TB-1:0];
    if (dbl_sel == '0) begin
      dbl_sel = imin;
    end
    lfsr_nxt   = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
    seed_eff   = (cfg_i.data == '0) ? RND_W'(1) : cfg_i.data;
    p_rank_inc = {1'b0, item_q.parent_rank} + 17'd1;
    better     = (rank_q == RANK_UNKNOWN) || ({1'b0, rank_q} > p_rank_inc);
    // shared compare/subtract step of the remainder unit
    rem_shift  = {rem_q, div_q[RND_W-1]};
    rem_sub    = rem_shift - {1'b0, span_q};
  end

  always_comb begin
    state_d     = state_q;
    min_int_d   = min_int_q;
    dbl_cnt_d   = dbl_cnt_q;
    red_d       = red_q;
    root_d      = root_q;
    seed_d      = seed_q;
    int_d       = int_q;
    fire_d      = fire_q;
    elapsed_d   = elapsed_q;
    cc_d        = cc_q;
    on_d        = on_q;
    solicit_d   = solicit_q;
    grounded_d  = grounded_q;
    rank_d      = rank_q;
    etx_d       = etx_q;
    parent_d    = parent_q;
    ver_d       = ver_q;
    lfsr_d      = lfsr_q;
    item_d      = item_q;
    send_d      = send_q;
    reply_d     = reply_q;
    stop_d      = stop_q;
    div_d       = div_q;
    half_d      = half_q;
    span_d      = span_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    start       = 1'b0;
    draw        = 1'b0;
    new_int     = int_q;
    new_half    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_i.valid) begin
          unique case (cfg_i.index)
            REG_MIN_INTERVAL: min_int_d = cfg_i.data[15:0];
            REG_DOUBLINGS:    dbl_cnt_d = cfg_i.data[4:0];
            REG_REDUNDANCY:   red_d     = cfg_i.data[7:0];
            REG_ROOT_MODE: begin
              root_d     = cfg_i.data[0];
              solicit_d  = !cfg_i.data[0];
              rank_d     = cfg_i.data[0] ? 16'd1 : RANK_UNKNOWN;
              etx_d      = cfg_i.data[0] ? 16'd0 : FLOAT_ETX;
              ver_d      = cfg_i.data[0] ? 8'd1 : 8'd0;
              grounded_d = cfg_i.data[0];
              parent_d   = '0;
            end
            REG_RANDOM_SEED: begin
              seed_d = cfg_i.data;
              lfsr_d = seed_eff;
            end
            default: ;
          endcase
        end
        if (in_i.valid) begin
          item_d  = in_i.data;
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        send_d  = 1'b0;
        reply_d = 1'b0;
        stop_d  = 1'b0;
        unique case (item_q.cmd)
          CMD_TICK: begin
            if (on_q) begin
              elapsed_d = el_inc;
              if (el_inc == fire_q && cc_q < red_q) begin
                send_d = 1'b1;
              end
              if (el_inc >= int_q) begin
                int_d     = dbl_sel;
                new_int   = dbl_sel;
                elapsed_d = '0;
                cc_d      = '0;
                draw      = 1'b1;
              end
            end
          end
          CMD_ADV: begin
            if (!root_q) begin
              if (solicit_q) begin
                stop_d    = 1'b1;
                solicit_d = 1'b0;
              end
              if (better) begin
                rank_d     = p_rank_inc[16] ? RANK_UNKNOWN : p_rank_inc[15:0];
                etx_d      = (item_q.parent_etx == ETX_MAX) ? ETX_MAX
                                                            : item_q.parent_etx + 16'd1;
                ver_d      = item_q.parent_version;
                grounded_d = 1'b1;
                parent_d   = item_q.source_id;
                start      = 1'b1;
              end else if (cc_q != 8'hFF) begin
                cc_d = cc_q + 8'd1;
              end
            end
          end
          CMD_SOL: begin
            if (grounded_q) begin
              reply_d = 1'b1;
              start   = !on_q;
            end
          end
          default: ;
        endcase

        if (start) begin
          int_d     = imin;
          new_int   = imin;
          elapsed_d = '0;
          cc_d      = '0;
          on_d      = 1'b1;
          draw      = 1'b1;
        end

        if (draw) begin
          new_half = new_int >> 1;
          lfsr_d   = lfsr_nxt;
          div_d    = lfsr_nxt;
          half_d   = new_half;
          span_d   = (new_int == new_half) ? TB'(1) : new_int - new_half;
          rem_d    = '0;
          cnt_d    = '0;
          state_d  = ST_DIV;
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_DIV: begin
        rem_d = rem_sub[TB] ? rem_shift[TB-1:0] : rem_sub[TB-1:0];
        div_d = div_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_STEP) begin
          fire_d  = half_q + TB'(1) + rem_d;
          cnt_d   = '0;
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.send_advert   = send_q;
          out_d.reply_advert  = reply_q;
          out_d.stop_solicit  = stop_q;
          out_d.node_rank     = rank_q;
          out_d.node_etx      = etx_q;
          out_d.node_version  = ver_q;
          out_d.is_grounded   = grounded_q;
          out_d.parent_id     = parent_q;
          out_d.timer_running = on_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_int_q   <= MIN_INT_RST;
      dbl_cnt_q   <= MAX_DOUBLINGS;
      red_q       <= 8'd1;
      root_q      <= 1'b0;
      seed_q      <= RND_W'(1);
      int_q       <= '0;
      fire_q      <= '0;
      elapsed_q   <= '0;
      cc_q        <= '0;
      on_q        <= 1'b0;
      solicit_q   <= 1'b1;
      grounded_q  <= 1'b0;
      rank_q      <= RANK_UNKNOWN;
      etx_q       <= FLOAT_ETX;
      parent_q    <= '0;
      ver_q       <= '0;
      lfsr_q      <= RND_W'(1);
      send_q      <= 1'b0;
      reply_q     <= 1'b0;
      stop_q      <= 1'b0;
      rem_q       <= '0;
      span_q      <= TB'(1);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_int_q   <= min_int_d;
      dbl_cnt_q   <= dbl_cnt_d;
      red_q       <= red_d;
      root_q      <= root_d;
      seed_q      <= seed_d;
      int_q       <= int_d;
      fire_q      <= fire_d;
      elapsed_q   <= elapsed_d;
      cc_q        <= cc_d;
      on_q        <= on_d;
      solicit_q   <= solicit_d;
      grounded_q  <= grounded_d;
      rank_q      <= rank_d;
      etx_q       <= etx_d;
      parent_q    <= parent_d;
      ver_q       <= ver_d;
      lfsr_q      <= lfsr_d;
      send_q      <= send_d;
      reply_q     <= reply_d;
      stop_q      <= stop_d;
      rem_q       <= rem_d;
      span_q      <= span_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    div_q  <= div_d;
    half_q <= half_d;
    out_q  <= out_d;
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // the remainder stays below the divisor during the divide
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < span_q))
    else $error("remainder not below divisor");

  // step counter only moves inside the divide
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DIV) |-> (cnt_q == '0))
    else $error("divider step count left nonzero");

  // a running timer has a fire point inside (I/2, I]
  a_fire_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && on_q) |->
      (int_q != '0 && fire_q <= int_q && fire_q > (int_q >> 1)))
    else $error("fire point outside interval");

endmodule

FILE: tb/trickle_timer_with_rank_update_tb.sv
// Testbench for trickle_timer_with_rank_update: a queue-fed driver, a monitor and a
// self-contained predictor of the Trickle timer, parent choice and rank state.
// Depends on ttru_pkg and the ttru_*_if channel interfaces.
module trickle_timer_with_rank_update_tb;
  import ttru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]      CMD_NONE    = 2'd3;
  localparam longint unsigned TMR_MAX     = (64'd1 << 32) - 1;
  localparam int              CYCLE_LIMIT = 1_000_000;
  localparam int              RAND_WORDS  = 1550;

  logic clk_i = 1'b0;
  logic rst_ni;

  ttru_in_if  in_if ();
  ttru_out_if out_if ();
  ttru_cfg_if cfg_if ();

  trickle_timer_with_rank_update u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register copies
  bit [15:0] cfg_min_ivl;
  bit [4:0]  cfg_dbl;
  bit [7:0]  cfg_redund;
  bit        cfg_root;
  bit [31:0] cfg_seed;

  // predicted Trickle and identity state
  longint unsigned trk_ivl, trk_fire, trk_elapsed;
  bit [7:0]  trk_cnt;
  bit        trk_on, sol_active, my_grounded;
  bit [15:0] my_rank, my_etx, my_parent;
  bit [7:0]  my_ver;
  bit [31:0] rng;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  out_word_t got_w, want_w;

  int n_queued, n_accepted, n_results, n_errors, n_cfg, n_send, n_reply, n_cycles;
  int tx_hold, rx_hold;
  bit quiet;

  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic longint unsigned ivl_floor();
    return (cfg_min_ivl == 16'd0) ? 64'd1 : 64'(cfg_min_ivl);
  endfunction

  // advance the Galois LFSR, then place the fire point in (I/2, I]
  function automatic void draw_fire();
    longint unsigned half, span;
    bit lsb;
    half = trk_ivl / 2;
    span = trk_ivl - half;
    lsb = rng[0];
    rng = rng >> 1;
    if (lsb) rng ^= LFSR_TAPS;
    if (span == 0) span = 1;
    trk_fire = half + 1 + (64'(rng) % span);
  endfunction

  function automatic void trickle_restart();
    trk_ivl = ivl_floor();
    trk_elapsed = 0;
    trk_cnt = '0;
    trk_on = 1'b1;
    draw_fire();
  endfunction

  function automatic void load_identity();
    sol_active = !cfg_root;
    my_rank = cfg_root ? 16'd1 : RANK_UNKNOWN;
    my_etx = cfg_root ? 16'd0 : FLOAT_ETX;
    my_ver = cfg_root ? 8'd1 : 8'd0;
    my_grounded = cfg_root;
    my_parent = '0;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    longint unsigned top, dbl;
    int unsigned sh;
    r = '0;
    case (w.cmd)
      CMD_TICK: begin
        if (trk_on) begin
          trk_elapsed = (trk_elapsed + 1) & TMR_MAX;
          if (trk_elapsed == trk_fire && trk_cnt < cfg_redund) r.send_advert = 1'b1;
          if (trk_elapsed >= trk_ivl) begin
            sh = (cfg_dbl > MAX_DOUBLINGS) ? MAX_DOUBLINGS : cfg_dbl;
            top = ivl_floor() << sh;
            if (top > TMR_MAX) top = TMR_MAX;
            dbl = trk_ivl * 2;
            trk_ivl = (dbl > top) ? top : dbl;
            if (trk_ivl == 0) trk_ivl = ivl_floor();
            trk_elapsed = 0;
            trk_cnt = '0;
            draw_fire();
          end
        end
      end
      CMD_ADV: begin
        if (!cfg_root) begin
          if (sol_active) begin
            r.stop_solicit = 1'b1;
            sol_active = 1'b0;
          end
          if (my_rank == RANK_UNKNOWN || 32'(my_rank) > 32'(w.parent_rank) + 32'd1) begin
            my_rank = (w.parent_rank == RANK_UNKNOWN) ? RANK_UNKNOWN : w.parent_rank + 16'd1;
            my_etx = (w.parent_etx == ETX_MAX) ? ETX_MAX : w.parent_etx + 16'd1;
            my_ver = w.parent_version;
            my_grounded = 1'b1;
            my_parent = w.source_id;
            trickle_restart();
          end else if (trk_cnt != 8'hFF) begin
            trk_cnt++;
          end
        end
      end
      CMD_SOL: begin
        if (my_grounded) begin
          r.reply_advert = 1'b1;
          if (!trk_on) trickle_restart();
        end
      end
      default: ;
    endcase
    r.node_rank = my_rank;
    r.node_etx = my_etx;
    r.node_version = my_ver;
    r.is_grounded = my_grounded;
    r.parent_id = my_parent;
    r.timer_running = trk_on;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("ERROR word %0d %s: got %0h expected %0h", n_results, field, got, want);
    n_errors++;
  endtask

  task automatic queue_word(logic [1:0] c, logic [15:0] rank, logic [15:0] etx,
                            logic [7:0] ver, logic [15:0] src);
    pending_words.push_back('{cmd: c, parent_rank: rank, parent_etx: etx,
                              parent_version: ver, source_id: src});
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_MIN_INTERVAL: cfg_min_ivl = val[15:0];
      REG_DOUBLINGS:    cfg_dbl = val[4:0];
      REG_REDUNDANCY:   cfg_redund = val[7:0];
      REG_ROOT_MODE: begin
        cfg_root = val[0];
        load_identity();
      end
      REG_RANDOM_SEED: begin
        cfg_seed = val;
        rng = (val == 32'd0) ? 32'd1 : val;
      end
      default: ;
    endcase
    n_cfg++;
  endtask

  // input driver: predicts each word as it is accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      tx_hold = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_words.push_back(predict_word(in_if.data));
        n_accepted++;
        tx_hold = pick_gap();
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_hold > 0) begin
          tx_hold--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_if.data  <= pending_words.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        got_w = out_if.data;
        if (got_w.send_advert === 1'b1) n_send++;
        if (got_w.reply_advert === 1'b1) n_reply++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", 64'(got_w), 0);
        end else begin
          want_w = expected_words.pop_front();
          if (got_w.send_advert !== want_w.send_advert)
            report_mismatch("send_advert", got_w.send_advert, want_w.send_advert);
          if (got_w.reply_advert !== want_w.reply_advert)
            report_mismatch("reply_advert", got_w.reply_advert, want_w.reply_advert);
          if (got_w.stop_solicit !== want_w.stop_solicit)
            report_mismatch("stop_solicit", got_w.stop_solicit, want_w.stop_solicit);
          if (got_w.node_rank !== want_w.node_rank)
            report_mismatch("node_rank", got_w.node_rank, want_w.node_rank);
          if (got_w.node_etx !== want_w.node_etx)
            report_mismatch("node_etx", got_w.node_etx, want_w.node_etx);
          if (got_w.node_version !== want_w.node_version)
            report_mismatch("node_version", got_w.node_version, want_w.node_version);
          if (got_w.is_grounded !== want_w.is_grounded)
            report_mismatch("is_grounded", got_w.is_grounded, want_w.is_grounded);
          if (got_w.parent_id !== want_w.parent_id)
            report_mismatch("parent_id", got_w.parent_id, want_w.parent_id);
          if (got_w.timer_running !== want_w.timer_running)
            report_mismatch("timer_running", got_w.timer_running, want_w.timer_running);
        end
        rx_hold = pick_gap();
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_if.ready <= (rx_hold == 0);
    end
  end

  initial begin
    n_cycles = 0;
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("timeout after %0d cycles", n_cycles);
    $display("trickle_timer_with_rank_update regression: fail");
    $finish;
  end

  initial begin
    int n_rand, n_phase, k, c;
    logic [15:0] rank, etx, min_v;
    logic [31:0] seed_v;

    cfg_min_ivl = MIN_INT_RST;
    cfg_dbl = MAX_DOUBLINGS;
    cfg_redund = 8'd1;
    cfg_root = 1'b0;
    cfg_seed = 32'd1;
    trk_ivl = 0;
    trk_fire = 0;
    trk_elapsed = 0;
    trk_cnt = '0;
    trk_on = 1'b0;
    load_identity();
    rng = 32'd1;
    quiet = 1'b0;

    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of reset: stopped tick, unknown command, floating node solicited
    queue_word(CMD_TICK, 16'h0, 16'h0, 8'h0, 16'h0);
    queue_word(CMD_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    queue_word(CMD_SOL, 16'h0, 16'h0, 8'h0, 16'h0);
    wait_idle();

    // root with zero interval, too many doublings, zero seed
    write_reg(REG_MIN_INTERVAL, 32'd0);
    write_reg(REG_DOUBLINGS, 32'd31);
    write_reg(REG_REDUNDANCY, 32'd0);
    write_reg(REG_RANDOM_SEED, 32'd0);
    write_reg(REG_ROOT_MODE, 32'd1);
    queue_word(CMD_ADV, 16'h0, 16'h0, 8'h7, 16'h1);
    queue_word(CMD_SOL, 16'h0, 16'h0, 8'h0, 16'h0);
    repeat (5) queue_word(CMD_TICK, 16'h0, 16'h0, 8'h0, 16'h0);
    queue_word(CMD_NONE, 16'h0, 16'h0, 8'h0, 16'h0);
    wait_idle();

    // floating node: saturating adoption, then ranks improving and consistent
    write_reg(REG_MIN_INTERVAL, 32'd2);
    write_reg(REG_DOUBLINGS, 32'd2);
    write_reg(REG_REDUNDANCY, 32'd1);
    write_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
    write_reg(REG_ROOT_MODE, 32'd0);
    queue_word(CMD_ADV, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    queue_word(CMD_ADV, 16'hFFFE, 16'hFFFE, 8'h55, 16'h1234);
    queue_word(CMD_ADV, 16'h0, 16'h0, 8'h0, 16'h0);
    queue_word(CMD_ADV, 16'h0, 16'h0, 8'hAA, 16'h4321);
    queue_word(CMD_ADV, 16'h3, 16'h9, 8'h2, 16'h8);
    queue_word(CMD_SOL, 16'h0, 16'h0, 8'h0, 16'h0);
    repeat (8) queue_word(CMD_TICK, 16'h0, 16'h0, 8'h0, 16'h0);
    wait_idle();

    write_reg(REG_MIN_INTERVAL, 32'hFFFF);
    write_reg(REG_DOUBLINGS, 32'd16);
    write_reg(REG_REDUNDANCY, 32'd255);
    write_reg(REG_ROOT_MODE, 32'd0);
    queue_word(CMD_ADV, 16'h7, 16'h20, 8'h3, 16'h99);
    repeat (2) queue_word(CMD_TICK, 16'h0, 16'h0, 8'h0, 16'h0);
    wait_idle();

    // consistent flood: counter must saturate and suppress the broadcast
    write_reg(REG_MIN_INTERVAL, 32'd3);
    write_reg(REG_DOUBLINGS, 32'd1);
    write_reg(REG_ROOT_MODE, 32'd0);
    queue_word(CMD_ADV, 16'd100, 16'd50, 8'h4, 16'h77);
    repeat (260) queue_word(CMD_ADV, 16'hFFFF, 16'($urandom), 8'($urandom), 16'($urandom));
    repeat (14) queue_word(CMD_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    n_rand = 275;
    wait_idle();

    n_phase = 0;
    while (n_rand < RAND_WORDS) begin
      k = $urandom_range(0, 9);
      if (k < 6) min_v = 16'($urandom_range(0, 6));
      else if (k < 8) min_v = 16'($urandom_range(7, 40));
      else if (k == 8) min_v = 16'hFFFF;
      else min_v = 16'($urandom);
      k = $urandom_range(0, 9);
      if (k == 0) seed_v = 32'd0;
      else if (k == 1) seed_v = 32'hFFFF_FFFF;
      else seed_v = $urandom;
      write_reg(REG_MIN_INTERVAL, 32'(min_v));
      write_reg(REG_DOUBLINGS, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                                          : $urandom_range(5, 31));
      write_reg(REG_REDUNDANCY, ($urandom_range(0, 9) == 0) ? 32'd255 : $urandom_range(0, 4));
      write_reg(REG_RANDOM_SEED, seed_v);
      write_reg(REG_ROOT_MODE, ($urandom_range(0, 4) == 0) ? 32'd1 : 32'd0);
      quiet = ($urandom_range(0, 3) == 0);

      repeat ($urandom_range(40, 140)) begin
        k = $urandom_range(0, 99);
        if (k < 62) begin
          queue_word(CMD_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
        end else if (k < 82) begin
          c = $urandom_range(0, 9);
          if (c < 6) rank = 16'($urandom_range(0, 300));
          else if (c < 8) rank = 16'($urandom_range(0, 65535));
          else begin
            case ($urandom_range(0, 2))
              0:       rank = 16'h0;
              1:       rank = 16'hFFFE;
              default: rank = 16'hFFFF;
            endcase
          end
          etx = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
          queue_word(CMD_ADV, rank, etx, 8'($urandom), 16'($urandom));
        end else if (k < 94) begin
          queue_word(CMD_SOL, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
        end else begin
          queue_word(CMD_NONE, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
        end
        n_rand++;
      end
      // sender holds off until the whole phase has drained
      wait_idle();
      n_phase++;
    end

    wait_idle();
    repeat (60) @(posedge clk_i);
    $display("ran %0d input words over %0d random phases, %0d register writes",
             n_accepted, n_phase, n_cfg);
    $display("checked %0d result words: %0d broadcasts, %0d replies, %0d errors",
             n_results, n_send, n_reply, n_errors);
    if (n_errors == 0) begin
      $display("trickle_timer_with_rank_update regression: pass");
    end else begin
      $display("trickle_timer_with_rank_update regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ttru_pkg.sv
rtl/core/ttru_if.sv
rtl/core/trickle_timer_with_rank_update.sv
tb/trickle_timer_with_rank_update_tb.sv
